/* sv/dtt_pkg.sv */
// Shared types, codes and helper functions for the DIV/TIMA/TMA/TAC timer block.
// Depends on nothing; dtt_step, the top level and the testbench refer to it by scoped names.
`default_nettype none

package dtt_pkg;

    // Function codes of an input beat; the spare code is ignored
    typedef enum logic [1:0] {
        FUNC_ADVANCE = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_WRITE   = 2'd2
    } func_t;

    // Register selectors
    typedef enum logic [1:0] {
        REG_DIV  = 2'd0,
        REG_CNT  = 2'd1,
        REG_TMA  = 2'd2,
        REG_TAC  = 2'd3
    } reg_t;

    localparam logic [4:0] TAC_READ_ONES = 5'h1F;
    localparam int unsigned EDGE_W       = 5;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] reg_sel;
        logic [7:0] write_data;
        logic [7:0] cycles;
    } item_t;

    typedef struct packed {
        logic [15:0] div;
        logic [7:0]  tima;
        logic [7:0]  tma;
        logic [2:0]  tac;
    } timer_state_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } result_t;

    typedef struct packed {
        logic       irq;
        logic [7:0] value;
    } bump_t;

    // Falling edges of the selected divider bit while the divider moves from
    // old to old + c (bit 9, 3, 5 or 7 for select 0..3)
    function automatic logic [EDGE_W-1:0] edge_count(logic [15:0] old, logic [7:0] c,
                                                     logic [1:0] sel);
        logic [16:0] sum;
        logic [16:0] diff;
        sum = {1'b0, old} + {9'd0, c};
        unique case (sel)
            2'd0:    diff = (sum >> 10) - ({1'b0, old} >> 10);
            2'd1:    diff = (sum >> 4) - ({1'b0, old} >> 4);
            2'd2:    diff = (sum >> 6) - ({1'b0, old} >> 6);
            default: diff = (sum >> 8) - ({1'b0, old} >> 8);
        endcase
        return diff[EDGE_W-1:0];
    endfunction

    // Value of the divider bit picked by a select code
    function automatic logic div_bit(logic [15:0] d, logic [1:0] sel);
        logic b;
        unique case (sel)
            2'd0:    b = d[9];
            2'd1:    b = d[3];
            2'd2:    b = d[5];
            default: b = d[7];
        endcase
        return b;
    endfunction

    // True when the divider bits below the selected bit hold a value under 4
    function automatic logic low_bits_small(logic [15:0] d, logic [1:0] sel);
        logic z;
        unique case (sel)
            2'd0:    z = (d[8:2] == 7'd0);
            2'd1:    z = (d[2] == 1'b0);
            2'd2:    z = (d[4:2] == 3'd0);
            default: z = (d[6:2] == 5'd0);
        endcase
        return z;
    endfunction

    // Add n ticks to the counter; on wrap add the reload value and flag it
    function automatic bump_t bump(logic [7:0] tima, logic [EDGE_W-1:0] n, logic [7:0] tma);
        logic [8:0] sum;
        bump_t      r;
        sum     = {1'b0, tima} + {{(9-EDGE_W){1'b0}}, n};
        r.irq   = sum[8];
        r.value = sum[8] ? (sum[7:0] + tma) : sum[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/dtt_step.sv */
// Next-state and result logic for one timer beat: catch up, then read or write.
// Depends on dtt_pkg for the item, state and result types and the helper functions.
`default_nettype none

module dtt_step (
    input  var dtt_pkg::item_t        item,
    input  var dtt_pkg::timer_state_t cur,
    output dtt_pkg::timer_state_t     nxt,
    output dtt_pkg::result_t          res
);

    logic [15:0]                  div_adv;
    logic [dtt_pkg::EDGE_W-1:0]   edges;
    logic                         timer_on;
    logic                         cur_bit;
    dtt_pkg::bump_t               b_adv;
    dtt_pkg::bump_t               b_tick;

    assign timer_on = cur.tac[2];
    assign div_adv  = cur.div + {8'd0, item.cycles};
    assign edges    = timer_on ? dtt_pkg::edge_count(cur.div, item.cycles, cur.tac[1:0])
                               : '0;
    assign b_adv    = dtt_pkg::bump(cur.tima, edges, cur.tma);
    // single extra tick on top of the catch-up, for the write quirks
    assign b_tick   = dtt_pkg::bump(b_adv.value, dtt_pkg::EDGE_W'(1), cur.tma);
    assign cur_bit  = timer_on && dtt_pkg::div_bit(div_adv, cur.tac[1:0]);

    always_comb
    begin
        nxt           = cur;
        res.read_data = 8'd0;
        res.timer_irq = 1'b0;
        unique case (item.func)
            dtt_pkg::FUNC_ADVANCE:
            begin
                nxt.div       = div_adv;
                nxt.tima      = b_adv.value;
                res.timer_irq = b_adv.irq;
            end
            dtt_pkg::FUNC_READ:
            begin
                unique case (item.reg_sel)
                    dtt_pkg::REG_DIV:  res.read_data = div_adv[15:8];
                    dtt_pkg::REG_CNT:
                    begin
                        if (b_adv.irq && dtt_pkg::low_bits_small(div_adv, cur.tac[1:0]))
                            res.read_data = 8'd0;
                        else
                            res.read_data = b_adv.value;
                    end
                    dtt_pkg::REG_TMA:  res.read_data = cur.tma;
                    default:           res.read_data = {dtt_pkg::TAC_READ_ONES, cur.tac};
                endcase
            end
            dtt_pkg::FUNC_WRITE:
            begin
                nxt.div       = div_adv;
                nxt.tima      = b_adv.value;
                res.timer_irq = b_adv.irq;
                unique case (item.reg_sel)
                    dtt_pkg::REG_DIV:
                    begin
                        nxt.div = 16'd0;
                        if (cur_bit)
                        begin
                            nxt.tima      = b_tick.value;
                            res.timer_irq = b_adv.irq | b_tick.irq;
                        end
                    end
                    dtt_pkg::REG_CNT:  nxt.tima = item.write_data;
                    dtt_pkg::REG_TMA:  nxt.tma  = item.write_data;
                    default:
                    begin
                        if (cur_bit && (!item.write_data[2] ||
                            !dtt_pkg::div_bit(div_adv, item.write_data[1:0])))
                        begin
                            nxt.tima      = b_tick.value;
                            res.timer_irq = b_adv.irq | b_tick.irq;
                        end
                        nxt.tac = item.write_data[2:0];
                    end
                endcase
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/div_tima_timer_registers.sv */
// Top level of the DIV/TIMA/TMA/TAC timer: input register, state, result register.
// Depends on dtt_pkg and dtt_step.
//
// Usage:
//   Input channel s_axis_*: one beat per timer event. tuser carries the function
//   (advance, register read, register write) and the register selector; tdata
//   carries the write byte and the number of cycles elapsed before the event.
//   Output channel m_axis_*: exactly one result beat per input beat, in order,
//   holding the read byte (zero unless a read) and the timer interrupt flag.
// Flow: a beat accepted into the input register is evaluated against the timer
//   state once the result register is empty or being drained, and its result
//   is registered in the result register, which drives m_axis.
// Throughput: one beat per cycle while m_axis_tready stays high; the whole update
//   is a single pass of shifts, adds and compares from input to state/result registers.
// Stall: while a result waits in the output register the input register still
//   takes one more beat; tready drops only when both registers are full.
// Reset: rst_n low clears the divider, TIMA, TMA and TAC (timer disabled) and
//   empties both registers; no result is pending after reset.
`default_nettype none

module div_tima_timer_registers (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [15:0] s_axis_tdata,   // [7:0] write_data, [15:8] cycles
    input  wire [3:0]  s_axis_tuser,   // [1:0] func, [3:2] reg_sel
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [7:0] read_data, [8] timer_irq, [15:9] zero
);

    dtt_pkg::item_t        in_item_reg;
    logic                  in_valid_reg;
    dtt_pkg::timer_state_t state_reg;
    dtt_pkg::timer_state_t state_next;
    dtt_pkg::result_t      result_next;
    dtt_pkg::result_t      out_reg;
    logic                  out_valid_reg;
    logic                  step;
    logic                  in_take;

    // Evaluate the held beat when the result register is empty or being drained
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    dtt_step u_step (
        .item (in_item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Input register: refill on every accepted beat, empty once evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.func       <= s_axis_tuser[1:0];
            in_item_reg.reg_sel    <= s_axis_tuser[3:2];
            in_item_reg.write_data <= s_axis_tdata[7:0];
            in_item_reg.cycles     <= s_axis_tdata[15:8];
        end
    end

    // Timer state: advance only when a beat is evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step)
            state_reg <= state_next;
    end

    // Result register: hold until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.timer_irq, out_reg.read_data};

endmodule

`default_nettype wire

/* sv/dtt_checker.sv */
// Port-level checker for the timer block, attached to the top level by bind.
// Depends only on the ports of div_tima_timer_registers.
`default_nettype none

module dtt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);

    // A stalled result beat holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Each accepted input beat must be followed by a valid result beat at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("result missing two cycles after input beat");

    // Back-pressure on the input only while a result is stuck at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // Padding bits of the result stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
        else $error("result padding bits not zero");

endmodule

bind div_tima_timer_registers dtt_checker u_dtt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* verif/tb_div_tima_timer_registers.sv */
// Self-checking testbench for the DIV/TIMA/TMA/TAC timer block: directed table, then random beats.
// Results are predicted in-bench and checked in order; needs dtt_pkg and the block's top level.
module tb_div_tima_timer_registers;
    timeunit 1ns;
    timeprecision 1ps;

    // The spare function code has no enum member in the package
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int unsigned RANDOM_BEATS = 900;

    typedef struct {
        dtt_pkg::item_t   beat;
        bit               fixed;   // want holds a typed-in result
        dtt_pkg::result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [7:0] write_data, [15:8] cycles
    logic [3:0]  s_axis_tuser = '0;    // [1:0] func, [3:2] reg_sel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [7:0] read_data, [8] timer_irq, [15:9] zero

    // Predicted timer state
    logic [15:0] div_count;
    logic [7:0]  tima_count;
    logic [7:0]  tma_value;
    logic [2:0]  tac_bits;

    dtt_pkg::result_t results_due[$];
    stim_row_t        directed_beats[$];
    dtt_pkg::result_t oldest_result;
    int unsigned      mismatch_count = 0;
    bit               quiet_spell = 1'b0;   // both sides run without idling while set

    div_tima_timer_registers u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Generous ceiling: every beat waiting out the longest gap and the longest stall
    // needs well under half a millisecond
    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Divider bit watched by the counter for a select code
    function automatic int unsigned tap_of(input logic [1:0] sel);
        case (sel)
            2'd0:    return 9;
            2'd1:    return 3;
            2'd2:    return 5;
            default: return 7;
        endcase
    endfunction

    // Falling edges of the tap while the divider runs from start to start + span,
    // counted without the 16-bit wrap so a carry out of the top still counts
    function automatic int unsigned falling_edges(input logic [15:0] start,
                                                  input logic [7:0] span,
                                                  input int unsigned pos);
        int unsigned from;
        int unsigned upto;
        from = start;
        upto = from + span;
        return (upto >> (pos + 1)) - (from >> (pos + 1));
    endfunction

    // Add ticks to TIMA; on wrap add TMA to the wrapped value and flag it
    function automatic logic tima_add(input int unsigned n);
        int unsigned sum;
        sum = tima_count + n;
        tima_count = sum[7:0];
        if (sum > 255)
        begin
            tima_count = tima_count + tma_value;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Move the divider on by span and, while the timer is enabled, tick TIMA for each tap edge
    function automatic logic run_divider(input logic [7:0] span);
        int unsigned edges;
        edges = falling_edges(div_count, span, tap_of(tac_bits[1:0]));
        div_count = div_count + span;
        if (!tac_bits[2])
            return 1'b0;
        return tima_add(edges);
    endfunction

    // TIMA as it will read once the divider has moved on by span; reads zero just after a wrap
    function automatic logic [7:0] tima_ahead(input logic [7:0] span);
        int unsigned pos;
        int unsigned edges;
        int unsigned sum;
        int unsigned low;
        logic [15:0] future;
        logic [7:0]  wrapped;
        pos = tap_of(tac_bits[1:0]);
        future = div_count + span;
        edges = tac_bits[2] ? falling_edges(div_count, span, pos) : 0;
        sum = tima_count + edges;
        wrapped = sum[7:0];
        if (sum <= 255)
            return wrapped;
        low = future & ((32'd1 << pos) - 1);
        if (low < 4)
            return 8'd0;
        return wrapped + tma_value;
    endfunction

    // Apply one beat to the predicted state and return the result it causes
    function automatic dtt_pkg::result_t timer_step(input dtt_pkg::item_t b);
        dtt_pkg::result_t r;
        logic [15:0]      div_before;
        logic [15:0]      future;
        logic             hit;
        r = '0;
        case (b.func)
            dtt_pkg::FUNC_ADVANCE:
                r.timer_irq = run_divider(b.cycles);
            dtt_pkg::FUNC_READ:
                case (b.reg_sel)
                    dtt_pkg::REG_DIV:
                    begin
                        future = div_count + b.cycles;
                        r.read_data = future[15:8];
                    end
                    dtt_pkg::REG_CNT: r.read_data = tima_ahead(b.cycles);
                    dtt_pkg::REG_TMA: r.read_data = tma_value;
                    default:          r.read_data = {dtt_pkg::TAC_READ_ONES, tac_bits};
                endcase
            dtt_pkg::FUNC_WRITE:
            begin
                r.timer_irq = run_divider(b.cycles);
                case (b.reg_sel)
                    dtt_pkg::REG_DIV:
                    begin
                        // Clearing the divider drops the tap if it was high
                        div_before = div_count;
                        div_count = '0;
                        if (tac_bits[2] && div_before[tap_of(tac_bits[1:0])])
                        begin
                            hit = tima_add(1);
                            r.timer_irq = r.timer_irq | hit;
                        end
                    end
                    dtt_pkg::REG_CNT: tima_count = b.write_data;
                    dtt_pkg::REG_TMA: tma_value = b.write_data;
                    default:
                    begin
                        // A high tap that the new setting turns off or moves to a low bit
                        if (tac_bits[2] && div_count[tap_of(tac_bits[1:0])] &&
                            (!b.write_data[2] || !div_count[tap_of(b.write_data[1:0])]))
                        begin
                            hit = tima_add(1);
                            r.timer_irq = r.timer_irq | hit;
                        end
                        tac_bits = b.write_data[2:0];
                    end
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    function automatic int unsigned idle_len();
        if (quiet_spell || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic queue_directed(input logic [1:0] fn, input logic [1:0] rs,
                                  input logic [7:0] wd, input logic [7:0] cyc,
                                  input bit fixed, input logic [7:0] rd, input logic irq);
        stim_row_t row;
        row.beat.func       = fn;
        row.beat.reg_sel    = rs;
        row.beat.write_data = wd;
        row.beat.cycles     = cyc;
        row.fixed           = fixed;
        row.want.read_data  = rd;
        row.want.timer_irq  = irq;
        directed_beats.push_back(row);
    endtask

    // Mostly well-formed register traffic, biased so TIMA sits near its wrap
    // and the timer is often enabled; a few beats carry the spare code
    function automatic stim_row_t random_row();
        stim_row_t   row;
        int unsigned pick;
        row.fixed = 1'b0;
        row.want = '0;
        row.beat.reg_sel = 2'($urandom_range(0, 3));
        row.beat.write_data = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            row.beat.func = FUNC_SPARE;
        else if (pick < 40)
            row.beat.func = dtt_pkg::FUNC_ADVANCE;
        else if (pick < 68)
            row.beat.func = dtt_pkg::FUNC_READ;
        else
            row.beat.func = dtt_pkg::FUNC_WRITE;
        if (row.beat.reg_sel == dtt_pkg::REG_CNT && $urandom_range(0, 1) == 1)
            row.beat.write_data = 8'($urandom_range(8'hF0, 8'hFF));
        if (row.beat.reg_sel == dtt_pkg::REG_TAC && $urandom_range(0, 9) < 7)
            row.beat.write_data[2] = 1'b1;
        case ($urandom_range(0, 7))
            0:       row.beat.cycles = 8'd0;
            1:       row.beat.cycles = 8'hFF;
            2, 3:    row.beat.cycles = 8'($urandom_range(0, 15));
            default: row.beat.cycles = 8'($urandom_range(0, 255));
        endcase
        return row;
    endfunction

    // Offer one beat from a falling edge; predict once it is taken. Valid stays
    // high across back-to-back beats.
    task automatic send_beat(input stim_row_t row);
        int unsigned      gap;
        dtt_pkg::result_t predicted;
        gap = idle_len();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.beat.cycles, row.beat.write_data};
        s_axis_tuser  <= {row.beat.reg_sel, row.beat.func};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = timer_step(row.beat);
        results_due.push_back(row.fixed ? row.want : predicted);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned n;
        div_count  = '0;
        tima_count = '0;
        tma_value  = '0;
        tac_bits   = '0;

        // Values straight out of reset, and the spare code
        queue_directed(dtt_pkg::FUNC_READ,    dtt_pkg::REG_TAC, 8'h00, 8'h00, 1, 8'hF8, 0);
        queue_directed(dtt_pkg::FUNC_READ,    dtt_pkg::REG_DIV, 8'h00, 8'h00, 1, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_READ,    dtt_pkg::REG_TMA, 8'hFF, 8'hFF, 1, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_READ,    dtt_pkg::REG_CNT, 8'h00, 8'hFF, 1, 8'h00, 0);
        queue_directed(FUNC_SPARE,            dtt_pkg::REG_TAC, 8'hFF, 8'hFF, 1, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_ADVANCE, dtt_pkg::REG_DIV, 8'h00, 8'hFF, 1, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_READ,    dtt_pkg::REG_DIV, 8'h00, 8'hFF, 0, 8'h00, 0);
        // Enable on bit 3 with TIMA two ticks short of its wrap and TMA at full scale
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_TMA, 8'hFF, 8'h00, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_CNT, 8'hFE, 8'h00, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_TAC, 8'h05, 8'h00, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_ADVANCE, dtt_pkg::REG_DIV, 8'h00, 8'h00, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_READ,    dtt_pkg::REG_CNT, 8'h00, 8'hFF, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_ADVANCE, dtt_pkg::REG_DIV, 8'h00, 8'hFF, 0, 8'h00, 0);
        // Divider clear with the tap low, control edges, then a divider clear with the tap high
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_DIV, 8'h00, 8'h08, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_ADVANCE, dtt_pkg::REG_DIV, 8'h00, 8'h08, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_TAC, 8'h00, 8'h00, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_TAC, 8'h07, 8'h00, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_CNT, 8'hFF, 8'h00, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_DIV, 8'h00, 8'h80, 0, 8'h00, 0);
        // Slowest tap, zero reload, then a lookahead read of TIMA
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_TMA, 8'h00, 8'hFF, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_TAC, 8'h04, 8'hFF, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_ADVANCE, dtt_pkg::REG_DIV, 8'h00, 8'hFF, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_READ,    dtt_pkg::REG_CNT, 8'h00, 8'hFF, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_WRITE,   dtt_pkg::REG_TAC, 8'hF9, 8'h11, 0, 8'h00, 0);
        queue_directed(dtt_pkg::FUNC_READ,    dtt_pkg::REG_TAC, 8'h00, 8'h00, 0, 8'h00, 0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_beats[i])
            send_beat(directed_beats[i]);

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            // Every fifth stretch of beats runs with no idling on either side
            quiet_spell = ((n / 80) % 5) == 4;
            send_beat(random_row());
        end
        quiet_spell = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain, then wait on for any stray beat
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("result beats missing at end of run");

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: drop tready for a randomly drawn stall, possibly none, before each beat
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_len();
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Check each taken result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_due.size() == 0)
                report_mismatch($sformatf("unexpected result beat 0x%04h", m_axis_tdata));
            else
            begin
                oldest_result = results_due.pop_front();
                if (m_axis_tdata[7:0] !== oldest_result.read_data)
                    report_mismatch($sformatf("read_data 0x%02h, predicted 0x%02h",
                                              m_axis_tdata[7:0], oldest_result.read_data));
                if (m_axis_tdata[8] !== oldest_result.timer_irq)
                    report_mismatch($sformatf("timer_irq %b, predicted %b",
                                              m_axis_tdata[8], oldest_result.timer_irq));
                if (m_axis_tdata[15:9] !== 7'd0)
                    report_mismatch($sformatf("padding bits 0x%02h not zero",
                                              m_axis_tdata[15:9]));
            end
        end
    end

endmodule
